// ===== sv/crz_pkg.sv =====
// Package for the circle rasterizer: field widths, request codes and step indexes.
// Depends on nothing; every other file of the block uses it by scoped names.
package crz_pkg;

    // Widths of the request and result fields.
    localparam int CENTER_W = 14;
    localparam int RAD_IN_W = 12;
    localparam int COORD_W  = 15;
    localparam int IDX_W    = 3;

    // Default width of the internal radius.
    localparam int RADIUS_BITS_DEF = 12;

    // Request codes on the type field.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // Index of the last result of one step in each mode.
    localparam logic [IDX_W-1:0] IDX_LAST_OUTLINE = 3'd7;
    localparam logic [IDX_W-1:0] IDX_LAST_FILL    = 3'd3;

    // Controls from the sequencer to the coordinate unit.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             fill;
    } t_coord_ctl;

endpackage

// ===== sv/crz_coord_unit.sv =====
// Coordinate unit of the circle rasterizer: one result per cycle from the
// center, the walk position and the result index. Depends on crz_pkg.
module crz_coord_unit #(
    parameter int XW = crz_pkg::RADIUS_BITS_DEF + 1
) (
    input  crz_pkg::t_coord_ctl                 i_ctl,
    input  logic signed [crz_pkg::CENTER_W-1:0] i_cx,
    input  logic signed [crz_pkg::CENTER_W-1:0] i_cy,
    input  logic        [XW-1:0]                i_x,
    input  logic        [XW-1:0]                i_y,
    output logic signed [crz_pkg::COORD_W-1:0]  o_x_start,
    output logic signed [crz_pkg::COORD_W-1:0]  o_x_end,
    output logic signed [crz_pkg::COORD_W-1:0]  o_row
);

    localparam int EW = (XW > crz_pkg::COORD_W) ? XW : crz_pkg::COORD_W;

    logic [EW-1:0]                 x_ext;
    logic [EW-1:0]                 y_ext;
    logic [crz_pkg::COORD_W-1:0]   x_w;
    logic [crz_pkg::COORD_W-1:0]   y_w;
    logic [crz_pkg::COORD_W-1:0]   cx_w;
    logic [crz_pkg::COORD_W-1:0]   cy_w;
    logic [crz_pkg::COORD_W-1:0]   col_off;
    logic [crz_pkg::COORD_W-1:0]   row_off;
    logic [crz_pkg::COORD_W-1:0]   col_minus;
    logic [crz_pkg::COORD_W-1:0]   col_plus;
    logic                          col_is_y;
    logic                          col_neg;
    logic                          row_neg;

    // All sums wrap to the result width, so operands are cut to it first.
    assign x_ext = EW'(i_x);
    assign y_ext = EW'(i_y);
    assign x_w   = x_ext[crz_pkg::COORD_W-1:0];
    assign y_w   = y_ext[crz_pkg::COORD_W-1:0];
    assign cx_w  = {i_cx[crz_pkg::CENTER_W-1], i_cx};
    assign cy_w  = {i_cy[crz_pkg::CENTER_W-1], i_cy};

    always_comb begin
        if (i_ctl.fill) begin
            col_is_y = (i_ctl.idx[0] == i_ctl.idx[1]);
            col_neg  = 1'b1;
            row_neg  = i_ctl.idx[1];
        end else begin
            col_is_y = i_ctl.idx[0];
            col_neg  = i_ctl.idx[1];
            row_neg  = i_ctl.idx[2];
        end
    end

    assign col_off   = col_is_y ? y_w : x_w;
    assign row_off   = col_is_y ? x_w : y_w;
    assign col_minus = cx_w - col_off;
    assign col_plus  = cx_w + col_off;

    assign o_x_start = col_neg ? col_minus : col_plus;
    assign o_x_end   = i_ctl.fill ? col_plus : o_x_start;
    assign o_row     = row_neg ? (cy_w - row_off) : (cy_w + row_off);

endmodule

// ===== sv/crz_err_unit.sv =====
// Error-term unit of the circle rasterizer: one walk step of the octant.
// Depends on crz_pkg only through the parameter defaults.
module crz_err_unit #(
    parameter int RB = crz_pkg::RADIUS_BITS_DEF
) (
    input  logic signed [RB+3:0] i_d,
    input  logic        [RB:0]   i_x,
    input  logic        [RB:0]   i_y,
    input  logic        [RB-1:0] i_rad,
    output logic signed [RB+3:0] o_d,
    output logic        [RB:0]   o_x,
    output logic        [RB:0]   o_y,
    output logic                 o_done
);

    localparam int DW = RB + 4;

    logic signed [DW-1:0] x_d;
    logic signed [DW-1:0] y_d;
    logic signed [DW-1:0] r_d;
    logic        [RB:0]   x_inc;
    logic signed [RB+1:0] y_dec;

    assign x_d   = $signed({3'b000, i_x});
    assign y_d   = $signed({3'b000, i_y});
    assign r_d   = $signed({4'b0000, i_rad});
    assign x_inc = i_x + 1'b1;
    // The row can drop below zero on a zero radius, so it is compared signed.
    assign y_dec = $signed({1'b0, i_y}) - $signed((RB+2)'(1));

    always_comb begin
        if (i_d >= (x_d <<< 1)) begin
            o_d = i_d - (x_d <<< 1) - DW'(1);
            o_x = x_inc;
            o_y = i_y;
        end else if (i_d < ((r_d - y_d) <<< 1)) begin
            o_d = i_d + (y_d <<< 1) - DW'(1);
            o_x = i_x;
            o_y = y_dec[RB:0];
        end else begin
            o_d = i_d + ((y_d - x_d - DW'(1)) <<< 1);
            o_x = x_inc;
            o_y = y_dec[RB:0];
        end
    end

    assign o_done = (o_y == i_y) ? ($signed({1'b0, i_y}) < $signed({1'b0, o_x}))
                                 : (y_dec < $signed({1'b0, o_x}));

endmodule

// ===== sv/circle_rasterizer_unit.sv =====
// Top level of the circle rasterizer: request port, step sequencer and state.
// Depends on crz_pkg, crz_coord_unit and crz_err_unit.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  request  | start in, busy out       | i_req_type, i_center_x, i_center_y,
//           |                          | i_radius, i_fill_mode
//  result   | o_valid strobe, no stall | o_x_start, o_x_end, o_row, o_step_last,
//           |                          | o_circle_last
//
// A request is taken at a rising edge with start high and busy low. A start
// request, or a next request while a circle is active, raises busy and the step
// sequencer then issues one result per cycle: eight in outline mode, four in fill
// mode. Busy stays high until the last result of the step, so no new request is
// taken during a step; one coordinate unit is reused for every result. A next
// request with no active circle gives nothing and leaves busy low. Reset is
// synchronous and active low; it clears the sequencer and the active flag. The
// receiver cannot stall: each result is shown for one cycle.
module circle_rasterizer_unit #(
    parameter int RADIUS_BITS = crz_pkg::RADIUS_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_req_type,
    input  logic signed [crz_pkg::CENTER_W-1:0]  i_center_x,
    input  logic signed [crz_pkg::CENTER_W-1:0]  i_center_y,
    input  logic        [crz_pkg::RAD_IN_W-1:0]  i_radius,
    input  logic                                 i_fill_mode,
    output logic                                 o_valid,
    output logic signed [crz_pkg::COORD_W-1:0]   o_x_start,
    output logic signed [crz_pkg::COORD_W-1:0]   o_x_end,
    output logic signed [crz_pkg::COORD_W-1:0]   o_row,
    output logic                                 o_step_last,
    output logic                                 o_circle_last
);

    localparam int RB = RADIUS_BITS;
    localparam int XW = RB + 1;
    localparam int DW = RB + 4;

    // Control state.
    logic                            r_busy, n_busy;
    logic                            r_active, n_active;
    logic [crz_pkg::IDX_W-1:0]       r_idx, n_idx;

    // Circle state; no reset needed, it is loaded by every start request.
    logic signed [crz_pkg::CENTER_W-1:0] r_cx, n_cx;
    logic signed [crz_pkg::CENTER_W-1:0] r_cy, n_cy;
    logic        [RB-1:0]                r_rad, n_rad;
    logic        [XW-1:0]                r_xs, n_xs;
    logic        [XW-1:0]                r_ys, n_ys;
    logic signed [DW-1:0]                r_d, n_d;
    logic                                r_fill, n_fill;

    logic                        accept;
    logic                        step_end;
    logic [crz_pkg::IDX_W-1:0]   idx_last;
    logic [RB+crz_pkg::RAD_IN_W-1:0] rad_wide;
    logic signed [DW-1:0]        adv_d;
    logic        [XW-1:0]        adv_x;
    logic        [XW-1:0]        adv_y;
    logic                        adv_done;
    crz_pkg::t_coord_ctl         coord_ctl;

    assign accept   = start && !r_busy;
    assign idx_last = r_fill ? crz_pkg::IDX_LAST_FILL : crz_pkg::IDX_LAST_OUTLINE;
    assign step_end = r_busy && (r_idx == idx_last);
    // Only the low RADIUS_BITS bits of the radius field count.
    assign rad_wide = {{RB{1'b0}}, i_radius};

    // The error term advances once per step, on the cycle of the step's
    // last result, so the end of the circle is known on that same result.
    crz_err_unit #(
        .RB(RB)
    ) u_err (
        .i_d    (r_d),
        .i_x    (r_xs),
        .i_y    (r_ys),
        .i_rad  (r_rad),
        .o_d    (adv_d),
        .o_x    (adv_x),
        .o_y    (adv_y),
        .o_done (adv_done)
    );

    assign coord_ctl.idx  = r_idx;
    assign coord_ctl.fill = r_fill;

    // One coordinate unit serves every result of a step, indexed by r_idx.
    crz_coord_unit #(
        .XW(XW)
    ) u_coord (
        .i_ctl     (coord_ctl),
        .i_cx      (r_cx),
        .i_cy      (r_cy),
        .i_x       (r_xs),
        .i_y       (r_ys),
        .o_x_start (o_x_start),
        .o_x_end   (o_x_end),
        .o_row     (o_row)
    );

    always_comb begin
        n_busy   = r_busy;
        n_active = r_active;
        n_idx    = r_idx;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rad    = r_rad;
        n_xs     = r_xs;
        n_ys     = r_ys;
        n_d      = r_d;
        n_fill   = r_fill;
        if (accept) begin
            if (i_req_type == crz_pkg::REQ_START) begin
                // A start drops any circle in progress and begins a new one.
                n_cx     = i_center_x;
                n_cy     = i_center_y;
                n_rad    = rad_wide[RB-1:0];
                n_fill   = i_fill_mode;
                n_xs     = '0;
                n_ys     = {1'b0, rad_wide[RB-1:0]};
                n_d      = $signed({4'b0000, rad_wide[RB-1:0]}) - DW'(1);
                n_active = 1'b1;
                n_busy   = 1'b1;
                n_idx    = '0;
            end else if (r_active) begin
                n_busy = 1'b1;
                n_idx  = '0;
            end
        end else if (r_busy) begin
            n_idx = r_idx + 1'b1;
            if (step_end) begin
                n_busy = 1'b0;
                n_xs   = adv_x;
                n_ys   = adv_y;
                n_d    = adv_d;
                if (adv_done) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_rad  <= n_rad;
        r_xs   <= n_xs;
        r_ys   <= n_ys;
        r_d    <= n_d;
        r_fill <= n_fill;
    end

    assign busy          = r_busy;
    assign o_valid       = r_busy;
    assign o_step_last   = step_end;
    assign o_circle_last = step_end && adv_done;

`ifndef SYNTHESIS
    // A start request always produces results in the following cycle.
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == crz_pkg::REQ_START)) |=> o_valid)
        else $error("start request did not begin a step");

    // The end of the circle can only be flagged on the last result of a step.
    a_circle_last_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_circle_last |-> (o_valid && o_step_last))
        else $error("circle end flagged inside a step");

    // After the last result of a step the sequencer stops and waits.
    a_step_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step_last |=> !o_valid)
        else $error("results continued past the end of a step");

    // Once the circle has ended no circle stays active.
    a_circle_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_circle_last |=> !r_active)
        else $error("circle still active after its last result");
`endif

endmodule

// ===== dv/circle_rasterizer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circle_rasterizer_unit: directed and random circle requests,
// with every emitted point or span checked against an in-bench predictor of the walk.
// Depends on crz_pkg and the circle_rasterizer_unit RTL.
module circle_rasterizer_unit_tb;

    localparam int RB         = crz_pkg::RADIUS_BITS_DEF;
    localparam int CW         = crz_pkg::CENTER_W;
    localparam int RW         = crz_pkg::RAD_IN_W;
    localparam int OW         = crz_pkg::COORD_W;
    localparam int RAND_ITEMS = 140;
    localparam int TAIL_WAIT  = 20;
    localparam int CYCLE_CAP  = 200000;
    localparam int SHOW_MAX   = 10;

    // One point or span as it leaves the block.
    typedef struct packed {
        logic signed [OW-1:0] x_start;
        logic signed [OW-1:0] x_end;
        logic signed [OW-1:0] row;
        logic                 step_last;
        logic                 circle_last;
    } t_span;

    // Tracks the circle walk and holds the spans still owed by the block.
    class t_raster_checker;
        t_span                    pending_spans[$];
        logic signed [CW-1:0]     ctr_x;
        logic signed [CW-1:0]     ctr_y;
        logic        [RB-1:0]     radius_q;
        logic                     fill_q;
        logic                     active_q;
        // The walk position and error term are kept as plain integers, since the
        // vertical position drops below zero on the final step of a tiny circle.
        int                       walk_x;
        int                       walk_y;
        int                       err_acc;
        int                       steps_done;
        int                       n_requests;
        int                       n_errors;

        function t_span mk(int a, int b, int r);
            t_span s;
            s.x_start     = a[OW-1:0];
            s.x_end       = b[OW-1:0];
            s.row         = r[OW-1:0];
            s.step_last   = 1'b0;
            s.circle_last = 1'b0;
            return s;
        endfunction

        // Andres error-term update for one step along the octant.
        function void advance();
            if (err_acc >= 2 * walk_x) begin
                err_acc -= 2 * walk_x + 1;
                walk_x++;
            end else if (err_acc < 2 * (int'(radius_q) - walk_y)) begin
                err_acc += 2 * walk_y - 1;
                walk_y--;
            end else begin
                err_acc += 2 * (walk_y - walk_x - 1);
                walk_y--;
                walk_x++;
            end
        endfunction

        function void emit_step();
            t_span s[8];
            int    n;
            int    x;
            int    y;
            x = walk_x;
            y = walk_y;
            if (fill_q) begin
                s[0] = mk(ctr_x - y, ctr_x + y, ctr_y + x);
                s[1] = mk(ctr_x - x, ctr_x + x, ctr_y + y);
                s[2] = mk(ctr_x - x, ctr_x + x, ctr_y - y);
                s[3] = mk(ctr_x - y, ctr_x + y, ctr_y - x);
                n = 4;
            end else begin
                s[0] = mk(ctr_x + x, ctr_x + x, ctr_y + y);
                s[1] = mk(ctr_x + y, ctr_x + y, ctr_y + x);
                s[2] = mk(ctr_x - x, ctr_x - x, ctr_y + y);
                s[3] = mk(ctr_x - y, ctr_x - y, ctr_y + x);
                s[4] = mk(ctr_x + x, ctr_x + x, ctr_y - y);
                s[5] = mk(ctr_x + y, ctr_x + y, ctr_y - x);
                s[6] = mk(ctr_x - x, ctr_x - x, ctr_y - y);
                s[7] = mk(ctr_x - y, ctr_x - y, ctr_y - x);
                n = 8;
            end
            s[n-1].step_last = 1'b1;
            advance();
            if (walk_y < walk_x) begin
                active_q = 1'b0;
                s[n-1].circle_last = 1'b1;
            end
            for (int k = 0; k < n; k++) pending_spans.push_back(s[k]);
            steps_done++;
        endfunction

        // Called for every accepted request.
        function void note_request(logic req_type, logic signed [CW-1:0] cx_in,
                                   logic signed [CW-1:0] cy_in,
                                   logic [RW-1:0] rad_in, logic fill_in);
            n_requests++;
            if (req_type == crz_pkg::REQ_START) begin
                ctr_x    = cx_in;
                ctr_y    = cy_in;
                radius_q = rad_in[RB-1:0];
                fill_q   = fill_in;
                walk_x   = 0;
                walk_y   = int'(radius_q);
                err_acc  = int'(radius_q) - 1;
                active_q = 1'b1;
                emit_step();
            end else if (active_q) begin
                emit_step();
            end
        endfunction

        // Called for every result strobe.
        function void check_span(t_span got);
            t_span want;
            if (pending_spans.size() == 0) begin
                n_errors++;
                if (n_errors <= SHOW_MAX)
                    $display("ERROR: unexpected result x_start=%0d x_end=%0d row=%0d sl=%0b cl=%0b",
                             got.x_start, got.x_end, got.row, got.step_last, got.circle_last);
                return;
            end
            want = pending_spans.pop_front();
            if (got !== want) begin
                n_errors++;
                if (n_errors <= SHOW_MAX) begin
                    $display("ERROR: expected x_start=%0d x_end=%0d row=%0d sl=%0b cl=%0b",
                             want.x_start, want.x_end, want.row, want.step_last,
                             want.circle_last);
                    $display("       actual   x_start=%0d x_end=%0d row=%0d sl=%0b cl=%0b",
                             got.x_start, got.x_end, got.row, got.step_last, got.circle_last);
                end
            end
        endfunction

        function int pending();
            return pending_spans.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_req_type;
    logic signed [CW-1:0]  i_center_x;
    logic signed [CW-1:0]  i_center_y;
    logic        [RW-1:0]  i_radius;
    logic                  i_fill_mode;
    logic                  o_valid;
    logic signed [OW-1:0]  o_x_start;
    logic signed [OW-1:0]  o_x_end;
    logic signed [OW-1:0]  o_row;
    logic                  o_step_last;
    logic                  o_circle_last;

    t_raster_checker raster_chk;
    logic            gaps_on;
    int              cycle_cnt;

    circle_rasterizer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_fill_mode   (i_fill_mode),
        .o_valid       (o_valid),
        .o_x_start     (o_x_start),
        .o_x_end       (o_x_end),
        .o_row         (o_row),
        .o_step_last   (o_step_last),
        .o_circle_last (o_circle_last)
    );

    always #5 i_clk = ~i_clk;

    // Results are checked before a request accepted at the same edge is noted, so the
    // order of expectations never depends on scheduling. All values are sampled at the
    // edge, before any nonblocking update of that edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                raster_chk.check_span({o_x_start, o_x_end, o_row, o_step_last,
                                       o_circle_last});
            if (start && !busy)
                raster_chk.note_request(i_req_type, i_center_x, i_center_y, i_radius,
                                        i_fill_mode);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("FAIL circle_rasterizer_unit");
            $finish;
        end
    end

    // Presents one request and returns at the edge that accepts it. While gaps are
    // enabled, start drops at random in any cycle of the wait, busy or not.
    task automatic send_req(input logic req_type, input logic signed [CW-1:0] cx,
                            input logic signed [CW-1:0] cy,
                            input logic [RW-1:0] rad, input logic fill);
        logic idle;
        i_req_type  <= req_type;
        i_center_x  <= cx;
        i_center_y  <= cy;
        i_radius    <= rad;
        i_fill_mode <= fill;
        do begin
            idle = gaps_on && ($urandom_range(99) < 31);
            start <= !idle;
            @(posedge i_clk);
        end while (idle || busy);
    endtask

    // A next request carries junk in the fields that the block must ignore.
    task automatic send_next();
        send_req(crz_pkg::REQ_NEXT, CW'($urandom), CW'($urandom), RW'($urandom),
                 1'($urandom));
    endtask

    function automatic logic signed [CW-1:0] pick_center();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return -14'sd8192;
        if (sel < 20) return 14'sd8191;
        return CW'($urandom);
    endfunction

    // Mostly small circles, so that whole walks to the closing step are common.
    task automatic run_circle();
        int sel;
        int rad;
        int steps;
        sel = $urandom_range(99);
        if (sel < 70)      rad = $urandom_range(24);
        else if (sel < 85) rad = $urandom_range(200);
        else               rad = $urandom_range(4095);
        send_req(crz_pkg::REQ_START, pick_center(), pick_center(), RW'(rad), 1'($urandom));
        if (rad <= 24) steps = $urandom_range(rad + 2, (rad * 3) / 4);
        else           steps = $urandom_range(8, 1);
        repeat (steps) send_next();
    endtask

    // Noise: stray next requests and starts abandoned after one to three steps.
    task automatic run_noise();
        if ($urandom_range(1) == 0) begin
            send_next();
        end else begin
            send_req(crz_pkg::REQ_START, pick_center(), pick_center(), RW'($urandom),
                     1'($urandom));
            repeat ($urandom_range(2)) send_next();
        end
    endtask

    initial begin
        int base;
        int done;
        raster_chk  = new();
        gaps_on     = 1'b1;
        cycle_cnt   = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = crz_pkg::REQ_START;
        i_center_x  = '0;
        i_center_y  = '0;
        i_radius    = '0;
        i_fill_mode = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Next with nothing active must be silent.
        send_next();
        // Zero radius, both modes: one step at the center, closing the circle.
        send_req(crz_pkg::REQ_START, 14'sd0, 14'sd0, 12'd0, 1'b0);
        send_next();
        send_req(crz_pkg::REQ_START, -14'sd8192, 14'sd8191, 12'd0, 1'b1);
        // Radius one runs two steps; the two trailing nexts find no circle.
        send_req(crz_pkg::REQ_START, 14'sd8191, -14'sd8192, 12'd1, 1'b0);
        repeat (3) send_next();
        // Largest radius in fill mode, then a restart while it is still active.
        send_req(crz_pkg::REQ_START, -14'sd8192, -14'sd8192, 12'd4095, 1'b1);
        repeat (2) send_next();
        send_req(crz_pkg::REQ_START, 14'sd8191, 14'sd8191, 12'd3, 1'b1);
        repeat (4) send_next();
        // Largest radius in outline mode at the far corner.
        send_req(crz_pkg::REQ_START, 14'sd8191, 14'sd8191, 12'd4095, 1'b0);
        send_next();

        // Random part; a middle stretch runs with no gaps at all.
        base = raster_chk.n_requests;
        done = 0;
        while (done < RAND_ITEMS) begin
            gaps_on = !(done >= 50 && done < 90);
            if ($urandom_range(99) < 80) run_circle();
            else                         run_noise();
            done = raster_chk.n_requests - base;
        end
        gaps_on = 1'b1;
        start <= 1'b0;

        while (raster_chk.pending() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (raster_chk.n_errors == 0 && raster_chk.pending() == 0) begin
            $display("PASS circle_rasterizer_unit");
        end else begin
            $display("FAIL circle_rasterizer_unit");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/crz_pkg.sv
sv/crz_coord_unit.sv
sv/crz_err_unit.sv
sv/circle_rasterizer_unit.sv
dv/circle_rasterizer_unit_tb.sv
